// File: design/ica_pkg.sv
// Shared types, constants and lookup functions for the IMU attitude core.
// Used by ica_div, ica_cordic and imu_complementary_attitude_core.
package ica_pkg;

    localparam int FRAC_BITS = 16;   // fraction bits of every Q value
    localparam int DIV_W     = 50;   // divider dividend magnitude width
    localparam int DEN_W     = 18;   // divider divisor width
    localparam int DIV_CNT_W = 6;    // divider iteration counter width
    localparam int CRD_W     = 35;   // CORDIC x/y datapath width
    localparam int ANG_W     = 26;   // CORDIC angle accumulator width
    localparam int LUT_IDX_W = 5;    // arctangent table index width
    localparam int ACC_W     = 61;   // blend accumulator width

    typedef enum logic [2:0] {
        CFG_ACCEL_RANGE   = 3'd0,
        CFG_GYRO_RANGE    = 3'd1,
        CFG_FILTER_TAU    = 3'd2,
        CFG_SAMPLE_PERIOD = 3'd3,
        CFG_CAL_POINTS    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // atan(2^-i) in degrees, Q.16
    function automatic logic [22:0] atan_lut(input logic [LUT_IDX_W-1:0] idx);
        logic [22:0] v;
        case (idx)
            5'd0:    v = 23'd2949120;
            5'd1:    v = 23'd1740967;
            5'd2:    v = 23'd919879;
            5'd3:    v = 23'd466945;
            5'd4:    v = 23'd234379;
            5'd5:    v = 23'd117304;
            5'd6:    v = 23'd58666;
            5'd7:    v = 23'd29335;
            5'd8:    v = 23'd14668;
            5'd9:    v = 23'd7334;
            5'd10:   v = 23'd3667;
            5'd11:   v = 23'd1833;
            5'd12:   v = 23'd917;
            5'd13:   v = 23'd458;
            5'd14:   v = 23'd229;
            5'd15:   v = 23'd115;
            5'd16:   v = 23'd57;
            5'd17:   v = 23'd29;
            5'd18:   v = 23'd14;
            5'd19:   v = 23'd7;
            5'd20:   v = 23'd4;
            5'd21:   v = 23'd2;
            5'd22:   v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

    // gyro sensitivity in tenths of an LSB per deg/s
    function automatic logic [10:0] gyro_tenths(input logic [1:0] rng);
        logic [10:0] v;
        case (rng)
            2'd0:    v = 11'd1310;
            2'd1:    v = 11'd655;
            2'd2:    v = 11'd328;
            default: v = 11'd164;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] sat_s32(input logic signed [ACC_W-1:0] v);
        logic [31:0] r;
        if (v[ACC_W-1:31] == '0 || v[ACC_W-1:31] == '1) begin
            r = v[31:0];
        end else begin
            r = v[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic [28:0] sat_s29(input logic signed [ACC_W-1:0] v);
        logic [28:0] r;
        if (v[ACC_W-1:28] == '0 || v[ACC_W-1:28] == '1) begin
            r = v[28:0];
        end else begin
            r = v[ACC_W-1] ? 29'h1000_0000 : 29'h0FFF_FFFF;
        end
        return r;
    endfunction

endpackage

// File: design/ica_div.sv
// Bit-serial restoring divider, floor division of a signed dividend by a
// positive divisor, one quotient bit per cycle. Depends on ica_pkg.
module ica_div
    import ica_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [DIV_W:0]   num,
    input  logic [DEN_W-1:0]        den,
    output logic signed [DIV_W:0]   quot,
    output unit_stat_t              stat
);

    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 neg_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_W:0]       mag_full;
    logic [DEN_W:0]       shifted;
    logic                 fits;

    // a negative dividend rounds toward minus infinity: divide |n|+d-1
    assign mag_full = num[DIV_W] ? ((~num) + 1'b1 + (DIV_W+1)'(den) - 1'b1) : num;
    assign shifted  = {rem_reg, quo_reg[DIV_W-1]};
    assign fits     = shifted >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !start && busy_reg && cnt_reg == DIV_CNT_W'(DIV_W - 1);
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= mag_full[DIV_W-1:0];
            neg_reg <= num[DIV_W];
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? DEN_W'(shifted - {1'b0, den_reg}) : shifted[DEN_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign quot = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign stat = '{busy: busy_reg, done: done_reg};

endmodule

// File: design/ica_cordic.sv
// Iterative vectoring CORDIC giving atan2(y, x) in degrees Q.16, one
// micro-rotation per cycle. Depends on ica_pkg for the arctangent table.
module ica_cordic
    import ica_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [15:0]      y_in,
    input  logic signed [15:0]      x_in,
    output logic signed [ANG_W-1:0] z_out,
    output unit_stat_t              stat
);

    localparam int CW = $clog2(CORDIC_STEPS);

    logic signed [CRD_W-1:0] x_reg;
    logic signed [CRD_W-1:0] y_reg;
    logic signed [ANG_W-1:0] z_reg;
    logic [CW-1:0]           i_reg;
    logic                    zero_reg;
    logic                    busy_reg;
    logic                    done_reg;

    logic signed [CRD_W-1:0] x0;
    logic signed [CRD_W-1:0] y0;
    logic signed [CRD_W-1:0] dx;
    logic signed [CRD_W-1:0] dy;
    logic signed [ANG_W-1:0] t_i;
    logic signed [ANG_W-1:0] half_turn;

    assign x0        = {{(CRD_W-32){x_in[15]}}, x_in, 16'b0};
    assign y0        = {{(CRD_W-32){y_in[15]}}, y_in, 16'b0};
    assign dx        = y_reg >>> i_reg;
    assign dy        = x_reg >>> i_reg;
    assign t_i       = $signed({{(ANG_W-23){1'b0}}, atan_lut(LUT_IDX_W'(i_reg))});
    assign half_turn = ANG_W'(180) <<< FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !start && busy_reg && i_reg == CW'(CORDIC_STEPS - 1);
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && i_reg == CW'(CORDIC_STEPS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            zero_reg <= (x_in == '0) && (y_in == '0);
            i_reg    <= '0;
            // fold the left half plane over before rotating
            if (x0 < 0) begin
                x_reg <= -x0;
                y_reg <= -y0;
                z_reg <= (y0 >= 0) ? half_turn : -half_turn;
            end else begin
                x_reg <= x0;
                y_reg <= y0;
                z_reg <= '0;
            end
        end else if (busy_reg) begin
            i_reg <= i_reg + 1'b1;
            if (y_reg >= 0) begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + t_i;
            end else begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - t_i;
            end
        end
    end

    assign z_out = zero_reg ? '0 : z_reg;
    assign stat  = '{busy: busy_reg, done: done_reg};

endmodule

// File: design/imu_complementary_attitude_core.sv
// Top level of the IMU complementary attitude core: sequencer, shared
// multiplier and state. Depends on ica_pkg, ica_div and ica_cordic.
//
// channel   direction  signals                         payload
// s_        in         s_tvalid s_tready s_tdata s_tuser  raw 6-axis sample, kind
// m_        out        m_tvalid m_tready m_tdata          attitude, g, rates
// cfg_      in         cfg_valid cfg_ready cfg_index cfg_data  register writes
//
// An attitude transaction runs three divisions on the shared bit-serial
// divider, one per axis, then eight multiplier steps and the output state.
// A calibration transaction only accumulates its sample, unless it closes a
// run and three offsets are divided out. s_tready is high only when idle.
// Reset is synchronous, active low, and clears all filter state.
// A finished result waits in the output register while the next sample runs.
module imu_complementary_attitude_core
    import ica_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    input  logic         s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [247:0] m_tdata,   // roll, pitch, yaw, accel_x_g, accel_y_g, accel_z_g,
                                    // rate_x, rate_y, rate_z, 2 zero bits
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [23:0]  cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CAL  = 5'b00010,
        ST_RATE = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]  accel_range_reg;
    logic [1:0]  gyro_range_reg;
    logic [16:0] filter_tau_reg;
    logic [23:0] sample_period_reg;
    logic [15:0] cal_points_reg;

    logic signed [15:0] acc_reg [3];
    logic signed [15:0] gyr_reg [3];
    logic [31:0]        off_reg [3];
    logic [31:0]        sum_reg [3];
    logic [15:0]        count_reg;
    logic [16:0]        cnt_reg;
    logic [31:0]        roll_reg;
    logic [31:0]        pitch_reg;
    logic [31:0]        yaw_reg;
    logic signed [28:0] rate_reg [3];
    logic signed [29:0] d_reg [3];
    logic signed [ANG_W-1:0] acc_pitch_reg;
    logic signed [ANG_W-1:0] acc_roll_reg;
    logic signed [ACC_W-1:0] accum_reg;
    logic signed [59:0] prod_reg;
    logic [1:0]  axis_reg;
    logic [2:0]  step_reg;
    logic        go_reg;
    logic        cord_sel_reg;
    logic        m_valid_reg;
    logic [247:0] m_data_reg;

    logic        in_acc;
    logic        cfg_acc;
    logic [15:0] cal_c;
    logic [15:0] cal_n;
    logic        cal_close;
    logic [31:0] sum_new [3];

    logic signed [DIV_W:0]   div_num;
    logic [DEN_W-1:0]        div_den;
    logic signed [DIV_W:0]   div_quot;
    unit_stat_t              div_stat;
    logic signed [47:0]      cal_scaled;
    logic signed [33:0]      rate_diff;
    logic signed [37:0]      rate_ext;
    logic signed [37:0]      rate_x10;
    logic [10:0]             tenths;
    logic signed [ACC_W-1:0] quot_ext;

    logic                    cord_start;
    logic signed [15:0]      cord_y;
    logic signed [15:0]      cord_x;
    logic signed [ANG_W-1:0] cord_z;
    unit_stat_t              cord_stat;

    logic signed [33:0]      mul_a;
    logic signed [25:0]      mul_b;
    logic signed [17:0]      one_minus_tau;
    logic signed [59:0]      d_round;
    logic signed [ACC_W-1:0] blend_sum;
    logic signed [ACC_W-1:0] blend_sh;
    logic [2:0]              ag_shift;
    logic signed [20:0]      ag [3];
    logic                    out_free;

    assign in_acc    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign out_free  = !m_valid_reg || m_tready;

    // calibration bookkeeping for the incoming transaction
    assign cal_c     = count_reg + 16'd1;
    assign cal_n     = (cal_points_reg == '0) ? 16'd1 : cal_points_reg;
    assign cal_close = (cal_c >= cal_n) || (cal_c == '0);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum_new[i] = sum_reg[i] + {{16{s_tdata[48 + 16*i + 15]}}, s_tdata[48 + 16*i +: 16]};
        end
    end

    // divider operands: rounded quotient is floor((2n + d) / 2d)
    assign cal_scaled = {sum_reg[axis_reg], 16'b0};
    assign tenths     = gyro_tenths(gyro_range_reg);
    assign rate_diff  = {{2{gyr_reg[axis_reg][15]}}, gyr_reg[axis_reg], 16'b0}
                      - {{2{off_reg[axis_reg][31]}}, off_reg[axis_reg]};
    assign rate_ext   = {{4{rate_diff[33]}}, rate_diff};
    assign rate_x10   = (rate_ext <<< 3) + (rate_ext <<< 1);

    always_comb begin
        if (state_reg == ST_CAL) begin
            div_num = {{2{cal_scaled[47]}}, cal_scaled, 1'b0} + {34'b0, cnt_reg};
            div_den = {cnt_reg, 1'b0};
        end else begin
            div_num = {{12{rate_x10[37]}}, rate_x10, 1'b0} + {40'b0, tenths};
            div_den = {6'b0, tenths, 1'b0};
        end
    end

    assign quot_ext = {{(ACC_W-DIV_W-1){div_quot[DIV_W]}}, div_quot};

    ica_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (go_reg),
        .num     (div_num),
        .den     (div_den),
        .quot    (div_quot),
        .stat    (div_stat)
    );

    // pitch angle first, roll chained on its completion
    assign cord_start = (in_acc && s_tuser) || (cord_stat.done && !cord_sel_reg);
    assign cord_y     = in_acc ? s_tdata[31:16] : acc_reg[0];
    assign cord_x     = in_acc ? s_tdata[47:32] : acc_reg[2];

    ica_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cord_start),
        .y_in    (cord_y),
        .x_in    (cord_x),
        .z_out   (cord_z),
        .stat    (cord_stat)
    );

    // shared multiplier operand select
    assign one_minus_tau = 18'sh10000 - $signed({1'b0, filter_tau_reg});

    always_comb begin
        case (step_reg)
            3'd0: begin
                mul_a = {{5{rate_reg[0][28]}}, rate_reg[0]};
                mul_b = {2'b0, sample_period_reg};
            end
            3'd1: begin
                mul_a = {{5{rate_reg[1][28]}}, rate_reg[1]};
                mul_b = {2'b0, sample_period_reg};
            end
            3'd2: begin
                mul_a = {{5{rate_reg[2][28]}}, rate_reg[2]};
                mul_b = {2'b0, sample_period_reg};
            end
            3'd3: begin
                mul_a = {{2{roll_reg[31]}}, roll_reg} - {{4{d_reg[1][29]}}, d_reg[1]};
                mul_b = {9'b0, filter_tau_reg};
            end
            3'd4: begin
                mul_a = {{(34-ANG_W){acc_roll_reg[ANG_W-1]}}, acc_roll_reg};
                mul_b = {{8{one_minus_tau[17]}}, one_minus_tau};
            end
            3'd5: begin
                mul_a = {{2{pitch_reg[31]}}, pitch_reg} + {{4{d_reg[0][29]}}, d_reg[0]};
                mul_b = {9'b0, filter_tau_reg};
            end
            3'd6: begin
                mul_a = {{(34-ANG_W){acc_pitch_reg[ANG_W-1]}}, acc_pitch_reg};
                mul_b = {{8{one_minus_tau[17]}}, one_minus_tau};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign d_round   = (prod_reg + (60'sd1 <<< 23)) >>> 24;
    assign blend_sum = accum_reg + {prod_reg[59], prod_reg} + (ACC_W'(1) <<< 15);
    assign blend_sh  = blend_sum >>> 16;

    assign ag_shift = {1'b0, accel_range_reg} + 3'd2;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ag[i] = {{5{acc_reg[i][15]}}, acc_reg[i]} <<< ag_shift;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_tuser) begin
                        state_next = ST_RATE;
                    end else if (cal_close) begin
                        state_next = ST_CAL;
                    end
                end
            end
            ST_CAL: begin
                if (div_stat.done && axis_reg == 2'd2) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RATE: begin
                if (div_stat.done && axis_reg == 2'd2) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (step_reg == 3'd7) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            go_reg            <= 1'b0;
            cord_sel_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
            accel_range_reg   <= 2'd1;
            gyro_range_reg    <= 2'd1;
            filter_tau_reg    <= 17'd64225;
            sample_period_reg <= 24'd67109;
            cal_points_reg    <= 16'd1;
            roll_reg          <= '0;
            pitch_reg         <= '0;
            yaw_reg           <= '0;
            count_reg         <= '0;
            for (int i = 0; i < 3; i++) begin
                off_reg[i] <= '0;
                sum_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            // start the divider on an attitude sample or a run-closing calibration sample, or on the next axis
            go_reg    <= (in_acc && (s_tuser || cal_close))
                      || ((state_reg == ST_CAL || state_reg == ST_RATE)
                          && div_stat.done && axis_reg != 2'd2);
            m_valid_reg <= (state_reg == ST_DONE && out_free) || (m_valid_reg && !m_tready);

            if (cfg_acc) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_ACCEL_RANGE:   accel_range_reg   <= cfg_data[1:0];
                    CFG_GYRO_RANGE:    gyro_range_reg    <= cfg_data[1:0];
                    CFG_FILTER_TAU:    filter_tau_reg    <= cfg_data[16:0];
                    CFG_SAMPLE_PERIOD: sample_period_reg <= cfg_data;
                    CFG_CAL_POINTS:    cal_points_reg    <= cfg_data[15:0];
                    default: ;
                endcase
            end

            if (cord_start) begin
                cord_sel_reg <= !in_acc;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_acc && !s_tuser) begin
                        for (int i = 0; i < 3; i++) begin
                            sum_reg[i] <= sum_new[i];
                        end
                        count_reg <= cal_c;
                    end
                end
                ST_CAL: begin
                    if (div_stat.done) begin
                        off_reg[axis_reg] <= sat_s32(quot_ext);
                        sum_reg[axis_reg] <= '0;
                        if (axis_reg == 2'd2) begin
                            count_reg <= '0;
                        end
                    end
                end
                ST_MUL: begin
                    if (step_reg == 3'd5) begin
                        roll_reg <= sat_s32(blend_sh);
                    end
                    if (step_reg == 3'd7) begin
                        pitch_reg <= sat_s32(blend_sh);
                        yaw_reg   <= yaw_reg + {{2{d_reg[2][29]}}, d_reg[2]};
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            for (int i = 0; i < 3; i++) begin
                acc_reg[i] <= s_tdata[16*i +: 16];
                gyr_reg[i] <= s_tdata[48 + 16*i +: 16];
            end
            cnt_reg  <= (cal_c == '0) ? 17'h10000 : {1'b0, cal_c};
            axis_reg <= '0;
        end else if (div_stat.done) begin
            axis_reg <= axis_reg + 2'd1;
        end

        if (state_reg == ST_RATE && div_stat.done) begin
            rate_reg[axis_reg] <= sat_s29(quot_ext);
        end

        if (cord_stat.done) begin
            if (cord_sel_reg) begin
                acc_roll_reg <= cord_z;
            end else begin
                acc_pitch_reg <= cord_z;
            end
        end

        if (state_reg == ST_MUL) begin
            step_reg <= step_reg + 3'd1;
            prod_reg <= mul_a * mul_b;
            case (step_reg)
                3'd1: d_reg[0] <= d_round[29:0];
                3'd2: d_reg[1] <= d_round[29:0];
                3'd3: d_reg[2] <= d_round[29:0];
                3'd4: accum_reg <= {prod_reg[59], prod_reg};
                3'd6: accum_reg <= {prod_reg[59], prod_reg};
                default: ;
            endcase
        end else begin
            step_reg <= '0;
        end

        if (state_reg == ST_DONE && out_free) begin
            m_data_reg <= {2'b0, rate_reg[2], rate_reg[1], rate_reg[0],
                           ag[2], ag[1], ag[0], yaw_reg, pitch_reg, roll_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // the divider only runs under a division state
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_CAL || state_reg == ST_RATE))
        else $error("divider finished outside a division state");

    // both arctangents must be ready before the blend starts
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL && step_reg == 3'd0) |-> !cord_stat.busy && !cord_start)
        else $error("CORDIC still busy at blend start");

    // no new sample while the divider is working
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_stat.busy)
        else $error("ready raised with divider busy");

    // a result is loaded only once the previous one has been taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_valid_reg && !m_tready) |=> state_reg == ST_DONE)
        else $error("result overwritten before transfer");

endmodule
